@@ design/lsc_pkg.sv @@
// Package for the line segment clipper: coordinate widths, outcode bits,
// register indexes and the controller/datapath command and status structs.
// No dependencies.
package lsc_pkg;

   localparam int CoordWidth = 16;
   localparam int SpanWidth  = CoordWidth + 1;
   localparam int ProdWidth  = 2 * SpanWidth;
   localparam int QuotWidth  = ProdWidth;
   localparam int CountWidth = $clog2(QuotWidth + 1);
   localparam int ClipLimit  = 4;
   localparam int ClipWidth  = 3;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [SpanWidth-1:0]  span_type;
   typedef logic [3:0]                   code_type;

   localparam code_type CodeInside = 4'b0000;
   localparam code_type CodeLeft   = 4'b0001;
   localparam code_type CodeRight  = 4'b0010;
   localparam code_type CodeBottom = 4'b0100;
   localparam code_type CodeTop    = 4'b1000;

   localparam logic [1:0] RegXMin = 2'd0;
   localparam logic [1:0] RegXMax = 2'd1;
   localparam logic [1:0] RegYMin = 2'd2;
   localparam logic [1:0] RegYMax = 2'd3;

   typedef struct packed {
      logic load;      // take the endpoints of a new segment
      logic setup;     // pick endpoint and edge, latch operands
      logic mult;      // form the product
      logic div_start; // load the divider
      logic div_step;  // one quotient bit
      logic commit;    // write the new endpoint back
   } cmd_type;

   typedef struct packed {
      logic accept;
      logic reject;
      logic div_done;
   } status_type;

endpackage

@@ design/lsc_if.sv @@
// Valid/ready channel interfaces of the line segment clipper.
// Depends on lsc_pkg.
interface lsc_req_if;
   logic valid;
   logic ready;
   lsc_pkg::coord_type start_x;
   lsc_pkg::coord_type start_y;
   lsc_pkg::coord_type end_x;
   lsc_pkg::coord_type end_y;
   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsc_rsp_if;
   logic valid;
   logic ready;
   logic visible;
   lsc_pkg::coord_type clipped_start_x;
   lsc_pkg::coord_type clipped_start_y;
   lsc_pkg::coord_type clipped_end_x;
   lsc_pkg::coord_type clipped_end_y;
   modport source (output valid, visible, clipped_start_x, clipped_start_y,
                   clipped_end_x, clipped_end_y, input ready);
   modport sink (input valid, visible, clipped_start_x, clipped_start_y,
                 clipped_end_x, clipped_end_y, output ready);
endinterface

@@ design/line_segment_clipper.sv @@
// Top level of the line segment clipper: window registers, output register,
// controller and datapath. Depends on lsc_pkg, lsc_if, lsc_controller and
// lsc_datapath.
//
// A segment beat on req (valid/ready) carries two endpoints; one result beat
// on rsp gives the visible flag and the clipped endpoints (all zero when
// not visible). The window is written through csr_write_enable/csr_index/
// csr_write_data; the user must write it only while the block is idle, as the
// block itself does not enforce this. Each clip step runs a test, a multiply,
// a divider load, 34 restoring divide steps and a done check, and a
// write-back; a final test ends the item. One item is in work at a time.
// The result sits in an output register, so the next segment is taken while
// rsp stalls; it then waits at its final test until the register frees.
// Reset (synchronous) empties the output register, idles the controller and
// restores the window to 0..639 by 0..479.
module line_segment_clipper (
   input  logic             clock,
   input  logic             reset,
   lsc_req_if.sink          req,
   lsc_rsp_if.source        rsp,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_index,
   input  lsc_pkg::coord_type csr_write_data
);
   lsc_pkg::coord_type x_min_ff, x_max_ff, y_min_ff, y_max_ff;
   logic               rsp_valid_ff, rsp_vis_ff;
   lsc_pkg::coord_type rsp_ax_ff, rsp_ay_ff, rsp_bx_ff, rsp_by_ff;
   lsc_pkg::cmd_type    cmd;
   lsc_pkg::status_type status;
   logic               out_load, out_visible;
   lsc_pkg::coord_type ax, ay, bx, by;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff <= 16'sd0;
         x_max_ff <= 16'sd639;
         y_min_ff <= 16'sd0;
         y_max_ff <= 16'sd479;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lsc_pkg::RegXMin: x_min_ff <= csr_write_data;
            lsc_pkg::RegXMax: x_max_ff <= csr_write_data;
            lsc_pkg::RegYMin: y_min_ff <= csr_write_data;
            lsc_pkg::RegYMax: y_max_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   lsc_controller u_ctrl (
      .clock, .reset,
      .in_valid (req.valid), .in_ready (req.ready),
      .out_load, .out_visible,
      .out_busy (rsp_valid_ff && !rsp.ready),
      .cmd, .status
   );

   lsc_datapath u_dp (
      .clock, .cmd, .status,
      .in_ax (req.start_x), .in_ay (req.start_y),
      .in_bx (req.end_x), .in_by (req.end_y),
      .x_min (x_min_ff), .x_max (x_max_ff), .y_min (y_min_ff), .y_max (y_max_ff),
      .ax, .ay, .bx, .by
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (out_load) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
      if (out_load) begin
         rsp_vis_ff <= out_visible;
         rsp_ax_ff  <= out_visible ? ax : '0;
         rsp_ay_ff  <= out_visible ? ay : '0;
         rsp_bx_ff  <= out_visible ? bx : '0;
         rsp_by_ff  <= out_visible ? by : '0;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.visible         = rsp_vis_ff;
   assign rsp.clipped_start_x = rsp_ax_ff;
   assign rsp.clipped_start_y = rsp_ay_ff;
   assign rsp.clipped_end_x   = rsp_bx_ff;
   assign rsp.clipped_end_y   = rsp_by_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp_ax_ff))
      else $error("result lost under stall");
   a_load: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !(rsp_valid_ff && !rsp.ready))
      else $error("result overwritten");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_vis_ff |-> rsp_ax_ff == '0 && rsp_by_ff == '0)
      else $error("rejected result not cleared");
endmodule

@@ design/lsc_datapath.sv @@
// Datapath of the line segment clipper: endpoints, outcodes, multiplier,
// restoring divider and saturating interpolation. Depends on lsc_pkg.
module lsc_datapath (
   input  logic                clock,
   input  lsc_pkg::cmd_type    cmd,
   output lsc_pkg::status_type status,
   input  lsc_pkg::coord_type  in_ax,
   input  lsc_pkg::coord_type  in_ay,
   input  lsc_pkg::coord_type  in_bx,
   input  lsc_pkg::coord_type  in_by,
   input  lsc_pkg::coord_type  x_min,
   input  lsc_pkg::coord_type  x_max,
   input  lsc_pkg::coord_type  y_min,
   input  lsc_pkg::coord_type  y_max,
   output lsc_pkg::coord_type  ax,
   output lsc_pkg::coord_type  ay,
   output lsc_pkg::coord_type  bx,
   output lsc_pkg::coord_type  by
);
   localparam int PW = lsc_pkg::ProdWidth;
   localparam int SW = lsc_pkg::SpanWidth;
   localparam int CW = lsc_pkg::CoordWidth;
   localparam int EW = PW + 2;

   lsc_pkg::coord_type ax_ff, ay_ff, bx_ff, by_ff;
   lsc_pkg::coord_type base_ff, edge_ff;
   logic               pick_b_ff, edge_y_ff, neg_ff;
   logic [SW-1:0]      mag_span_ff, mag_num_ff, mag_den_ff;
   logic               den_zero_ff;
   logic [PW-1:0]      quot_ff;
   logic [SW:0]        rem_ff;
   logic [lsc_pkg::CountWidth-1:0] count_ff;

   function automatic lsc_pkg::code_type outcode(lsc_pkg::coord_type x,
                                                 lsc_pkg::coord_type y,
                                                 lsc_pkg::coord_type xl,
                                                 lsc_pkg::coord_type xh,
                                                 lsc_pkg::coord_type yl,
                                                 lsc_pkg::coord_type yh);
      lsc_pkg::code_type c;
      c = lsc_pkg::CodeInside;
      if (x < xl) c = c | lsc_pkg::CodeLeft;
      else if (x > xh) c = c | lsc_pkg::CodeRight;
      if (y < yl) c = c | lsc_pkg::CodeBottom;
      else if (y > yh) c = c | lsc_pkg::CodeTop;
      return c;
   endfunction

   function automatic logic [SW-1:0] mag(lsc_pkg::span_type v);
      return v[SW-1] ? SW'(-v) : SW'(v);
   endfunction

   lsc_pkg::code_type ca, cb, pick;
   assign ca   = outcode(ax_ff, ay_ff, x_min, x_max, y_min, y_max);
   assign cb   = outcode(bx_ff, by_ff, x_min, x_max, y_min, y_max);
   assign pick = (cb > ca) ? cb : ca;

   assign status.accept = (ca | cb) == lsc_pkg::CodeInside;
   assign status.reject = (ca & cb) != lsc_pkg::CodeInside;
   assign status.div_done = (count_ff == '0);

   lsc_pkg::span_type sp, nm, dn;
   lsc_pkg::coord_type edge_sel;
   logic               use_y;
   always_comb begin
      use_y = (pick & (lsc_pkg::CodeTop | lsc_pkg::CodeBottom)) != '0;
      if ((pick & lsc_pkg::CodeTop) != '0) edge_sel = y_max;
      else if ((pick & lsc_pkg::CodeBottom) != '0) edge_sel = y_min;
      else if ((pick & lsc_pkg::CodeRight) != '0) edge_sel = x_max;
      else edge_sel = x_min;
      if (use_y) begin
         sp = SW'(bx_ff) - SW'(ax_ff);
         nm = SW'(edge_sel) - SW'(ay_ff);
         dn = SW'(by_ff) - SW'(ay_ff);
      end else begin
         sp = SW'(by_ff) - SW'(ay_ff);
         nm = SW'(edge_sel) - SW'(ax_ff);
         dn = SW'(bx_ff) - SW'(ax_ff);
      end
   end

   logic [SW:0] trial;
   assign trial = {rem_ff[SW-1:0], quot_ff[PW-1]} - {1'b0, mag_den_ff};

   logic signed [EW-1:0] sum;
   lsc_pkg::coord_type   interp;
   always_comb begin
      sum = neg_ff ? EW'(base_ff) - EW'(quot_ff) : EW'(base_ff) + EW'(quot_ff);
      if (den_zero_ff) interp = base_ff;
      else if (sum > EW'(lsc_pkg::coord_type'({1'b0, {(CW-1){1'b1}}})))
         interp = {1'b0, {(CW-1){1'b1}}};
      else if (sum < -$signed(EW'({1'b1, {(CW-1){1'b0}}})))
         interp = {1'b1, {(CW-1){1'b0}}};
      else interp = sum[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff <= in_ax; ay_ff <= in_ay; bx_ff <= in_bx; by_ff <= in_by;
      end
      if (cmd.setup) begin
         pick_b_ff   <= (pick != ca);
         edge_y_ff   <= use_y;
         edge_ff     <= edge_sel;
         base_ff     <= use_y ? ax_ff : ay_ff;
         mag_span_ff <= mag(sp);
         mag_num_ff  <= mag(nm);
         mag_den_ff  <= mag(dn);
         den_zero_ff <= (dn == '0);
         neg_ff      <= (sp[SW-1] ^ nm[SW-1]) ^ dn[SW-1];
      end
      if (cmd.mult) quot_ff <= mag_span_ff * mag_num_ff;
      if (cmd.div_start) begin
         rem_ff   <= '0;
         count_ff <= lsc_pkg::CountWidth'(PW);
      end
      if (cmd.div_step) begin
         if (!trial[SW]) begin
            rem_ff  <= {1'b0, trial[SW-1:0]};
            quot_ff <= {quot_ff[PW-2:0], 1'b1};
         end else begin
            rem_ff  <= {rem_ff[SW-1:0], quot_ff[PW-1]};
            quot_ff <= {quot_ff[PW-2:0], 1'b0};
         end
         count_ff <= count_ff - 1'b1;
      end
      if (cmd.commit) begin
         if (pick_b_ff) begin
            bx_ff <= edge_y_ff ? interp : edge_ff;
            by_ff <= edge_y_ff ? edge_ff : interp;
         end else begin
            ax_ff <= edge_y_ff ? interp : edge_ff;
            ay_ff <= edge_y_ff ? edge_ff : interp;
         end
      end
   end

   assign ax = ax_ff;
   assign ay = ay_ff;
   assign bx = bx_ff;
   assign by = by_ff;
endmodule

@@ design/lsc_controller.sv @@
// Controller of the line segment clipper: sequences test, multiply, divide
// and write-back for up to four clip steps. Depends on lsc_pkg.
module lsc_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   output logic                out_load,
   output logic                out_visible,
   input  logic                out_busy,
   output lsc_pkg::cmd_type    cmd,
   input  lsc_pkg::status_type status
);
   typedef enum logic [5:0] {
      Idle   = 6'b000001,
      Test   = 6'b000010,
      Mult   = 6'b000100,
      DivGo  = 6'b001000,
      Divide = 6'b010000,
      Commit = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [lsc_pkg::ClipWidth-1:0] clips_ff, clips_in;

   always_comb begin
      state_in    = state_ff;
      clips_in    = clips_ff;
      cmd         = '0;
      in_ready    = 1'b0;
      out_load    = 1'b0;
      out_visible = 1'b0;
      unique case (state_ff)
         Idle: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               clips_in = '0;
               state_in = Test;
            end
         end
         Test: begin
            if (status.accept || status.reject ||
                clips_ff == lsc_pkg::ClipWidth'(lsc_pkg::ClipLimit)) begin
               if (!out_busy) begin
                  out_load    = 1'b1;
                  out_visible = status.accept;
                  state_in    = Idle;
               end
            end else begin
               cmd.setup = 1'b1;
               state_in  = Mult;
            end
         end
         Mult: begin
            cmd.mult = 1'b1;
            state_in = DivGo;
         end
         DivGo: begin
            cmd.div_start = 1'b1;
            state_in      = Divide;
         end
         Divide: begin
            if (status.div_done) state_in = Commit;
            else cmd.div_step = 1'b1;
         end
         Commit: begin
            cmd.commit = 1'b1;
            clips_in   = clips_ff + 1'b1;
            state_in   = Test;
         end
         default: state_in = Idle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Idle;
         clips_ff <= '0;
      end else begin
         state_ff <= state_in;
         clips_ff <= clips_in;
      end
   end
endmodule
